>>> hdl/stroke_font_text_generator_unit_assert.svh
// ----------------------------------------------------------------------------
// Stroke font text generator assertion macros
// Shared concurrent assertion forms used by the checker of the generator.
// ----------------------------------------------------------------------------
`ifndef STROKE_FONT_TEXT_GENERATOR_UNIT_ASSERT_SVH
`define STROKE_FONT_TEXT_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define SFTG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define SFTG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication that is also checked during reset.
`define SFTG_ASSERT_RAW(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/sftg_pkg.sv
// ----------------------------------------------------------------------------
// Stroke font text generator package
// Widths, character codes, controller types and the stroke font tables.
// ----------------------------------------------------------------------------
package sftg_pkg;

    localparam int GLYPH_COUNT = 45;
    localparam int MAX_STROKES = 5;
    localparam int COORD_BITS  = 14;

    localparam int CURSOR_W   = 10;
    localparam int GLYPH_W    = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
    localparam int SEG_IDX_W  = (MAX_STROKES > 1) ? $clog2(MAX_STROKES) : 1;
    localparam int CNT_W      = $clog2(MAX_STROKES + 1);
    localparam int BASE_W     = CURSOR_W + 4;
    localparam int SUM_W      = ((BASE_W > COORD_BITS) ? BASE_W : COORD_BITS) + 1;

    typedef logic [CURSOR_W-1:0]   cursor_t;
    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [GLYPH_W-1:0]    glyph_idx_t;
    typedef logic [SEG_IDX_W-1:0]  seg_idx_t;
    typedef logic [CNT_W-1:0]      seg_cnt_t;
    // One stroke: x0, y0, x1, y1 as signed nibbles in quarter units, y upward.
    typedef logic [15:0]           stroke_t;

    localparam cursor_t    CURSOR_MAX   = 10'd1023;
    localparam cursor_t    WRAP_RESET   = 10'd80;
    localparam logic [7:0] CODE_SPACE   = 8'd32;
    localparam logic [7:0] CODE_NEWLINE = 8'd10;
    localparam logic [7:0] FIRST_GLYPH  = 8'd46;
    localparam logic [7:0] LAST_GLYPH   = 8'(46 + GLYPH_COUNT - 1);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } sftg_state_t;

    typedef struct packed {
        logic accept;
        logic load_seg;
    } sftg_cmd_t;

    typedef struct packed {
        logic has_glyph;
        logic last_seg;
        logic out_free;
    } sftg_status_t;

    localparam seg_cnt_t SEG_COUNT [GLYPH_COUNT] = '{
        3'd4, 3'd1, 3'd4, 3'd1, 3'd4, 3'd4, 3'd3, 3'd5, 3'd5, 3'd2,
        3'd5, 3'd5, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd5, 3'd1, 3'd3,
        3'd5, 3'd3, 3'd3, 3'd4, 3'd3, 3'd5, 3'd3, 3'd3, 3'd4, 3'd3,
        3'd2, 3'd4, 3'd3, 3'd4, 3'd3, 3'd5, 3'd4, 3'd3, 3'd2, 3'd3,
        3'd2, 3'd4, 3'd2, 3'd3, 3'd3
    };

    // Glyphs from '.' to 'Z'. The dot collapses to four zero-length strokes.
    localparam stroke_t GLYPH_ROM [GLYPH_COUNT][MAX_STROKES] = '{
        '{16'h0C0C, 16'h0C0C, 16'h0C0C, 16'h0C0C, 16'h0000},
        '{16'h44CC, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'hC444, 16'hC4CC, 16'hCC4C, 16'h444C, 16'h0000},
        '{16'h040C, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'hC004, 16'h0440, 16'h40CC, 16'hCC4C, 16'h0000},
        '{16'hC444, 16'hC040, 16'hCC4C, 16'h444C, 16'h0000},
        '{16'hC4C0, 16'hC040, 16'h444C, 16'h0000, 16'h0000},
        '{16'h44C4, 16'hC4C0, 16'hC040, 16'h404C, 16'h4CCC},
        '{16'h44C4, 16'hC4CC, 16'hCC4C, 16'h4C40, 16'h40C0},
        '{16'hC444, 16'h44CC, 16'h0000, 16'h0000, 16'h0000},
        '{16'hCCC4, 16'hC444, 16'h444C, 16'h4CCC, 16'hC040},
        '{16'hC0C4, 16'hC444, 16'h444C, 16'h4CCC, 16'hC040},
        '{16'h0301, 16'h0D01, 16'h0000, 16'h0000, 16'h0000},
        '{16'h0301, 16'h0DF1, 16'h0000, 16'h0000, 16'h0000},
        '{16'h44C0, 16'hC04C, 16'h0000, 16'h0000, 16'h0000},
        '{16'hC242, 16'hCE4E, 16'h0000, 16'h0000, 16'h0000},
        '{16'hC440, 16'h40CC, 16'h0000, 16'h0000, 16'h0000},
        '{16'hC444, 16'h4440, 16'h4000, 16'h000F, 16'h0D0C},
        '{16'hCC44, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{16'hCC04, 16'h044C, 16'hE020, 16'h0000, 16'h0000},
        '{16'hC4CC, 16'hC442, 16'h42C0, 16'hC04E, 16'h4ECC},
        '{16'hC444, 16'hC4CC, 16'hCC4C, 16'h0000, 16'h0000},
        '{16'hC4CC, 16'hC440, 16'h40CC, 16'h0000, 16'h0000},
        '{16'hC444, 16'hC4CC, 16'hCC4C, 16'hC040, 16'h0000},
        '{16'hC444, 16'hC4CC, 16'hC040, 16'h0000, 16'h0000},
        '{16'hC444, 16'hC4CC, 16'hCC4C, 16'h4C40, 16'h4000},
        '{16'hC4CC, 16'h444C, 16'hC040, 16'h0000, 16'h0000},
        '{16'hC444, 16'h040C, 16'hCC4C, 16'h0000, 16'h0000},
        '{16'hC444, 16'h040C, 16'hCC0C, 16'hCCC0, 16'h0000},
        '{16'hC4CC, 16'hC044, 16'hC04C, 16'h0000, 16'h0000},
        '{16'hC4CC, 16'hCC4C, 16'h0000, 16'h0000, 16'h0000},
        '{16'hC4CC, 16'hC400, 16'h0044, 16'h444C, 16'h0000},
        '{16'hC4CC, 16'hC44C, 16'h444C, 16'h0000, 16'h0000},
        '{16'hC444, 16'hC4CC, 16'hCC4C, 16'h444C, 16'h0000},
        '{16'hC4CC, 16'hC442, 16'h42C0, 16'h0000, 16'h0000},
        '{16'hC444, 16'hC4CC, 16'hCC4C, 16'h444C, 16'h004C},
        '{16'hC4CC, 16'hC442, 16'h42C0, 16'hC04C, 16'h0000},
        '{16'h44C2, 16'hC24E, 16'h4ECC, 16'h0000, 16'h0000},
        '{16'hC444, 16'h040C, 16'h0000, 16'h0000, 16'h0000},
        '{16'hC4CC, 16'hCC4C, 16'h444C, 16'h0000, 16'h0000},
        '{16'hC40C, 16'h0C44, 16'h0000, 16'h0000, 16'h0000},
        '{16'hC4CC, 16'hCC00, 16'h004C, 16'h4C44, 16'h0000},
        '{16'hC44C, 16'hCC44, 16'h0000, 16'h0000, 16'h0000},
        '{16'hC400, 16'h4400, 16'h000C, 16'h0000, 16'h0000},
        '{16'hC444, 16'h44CC, 16'hCC4C, 16'h0000, 16'h0000}
    };

    function automatic cursor_t sat_inc(input cursor_t v);
        return (v == CURSOR_MAX) ? v : v + cursor_t'(1);
    endfunction

endpackage

>>> hdl/sftg_char_if.sv
// ----------------------------------------------------------------------------
// Stroke font character channel
// Valid/ready channel that carries one text character per transaction.
// ----------------------------------------------------------------------------
interface sftg_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       start_of_text;

    modport source (output valid, output char_code, output start_of_text, input ready);
    modport sink   (input valid, input char_code, input start_of_text, output ready);
endinterface

>>> hdl/sftg_seg_if.sv
// ----------------------------------------------------------------------------
// Stroke font segment channel
// Valid/ready channel that carries one line segment per transaction.
// ----------------------------------------------------------------------------
interface sftg_seg_if;
    logic                       valid;
    logic                       ready;
    logic [sftg_pkg::COORD_BITS-1:0] start_x;
    logic [sftg_pkg::COORD_BITS-1:0] start_y;
    logic [sftg_pkg::COORD_BITS-1:0] end_x;
    logic [sftg_pkg::COORD_BITS-1:0] end_y;
    logic                       last_segment;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, output last_segment, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, input last_segment, output ready);
endinterface

>>> hdl/sftg_ctrl.sv
// ----------------------------------------------------------------------------
// Stroke font text generator controller
// Accepts characters and sequences the strokes of a glyph into the output.
// ----------------------------------------------------------------------------
module sftg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sftg_pkg::sftg_status_t status,
    output sftg_pkg::sftg_cmd_t   cmd
);

    sftg_pkg::sftg_state_t state_reg;
    sftg_pkg::sftg_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sftg_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sftg_pkg::ST_IDLE:
            begin
                if (in_valid && status.has_glyph)
                begin
                    state_next = sftg_pkg::ST_EMIT;
                end
            end
            sftg_pkg::ST_EMIT:
            begin
                if (status.out_free && status.last_seg)
                begin
                    state_next = sftg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sftg_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.load_seg = 1'b0;
        unique case (state_reg)
            sftg_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            sftg_pkg::ST_EMIT:
            begin
                cmd.load_seg = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> hdl/sftg_datapath.sv
// ----------------------------------------------------------------------------
// Stroke font text generator datapath
// Cursor registers, wrap register, glyph lookup and the segment output stage.
// ----------------------------------------------------------------------------
module sftg_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sftg_pkg::sftg_cmd_t           cmd,
    output sftg_pkg::sftg_status_t        status,
    input  logic [7:0]                    char_code,
    input  logic                          start_of_text,
    input  logic                          wrap_column_we,
    input  logic [sftg_pkg::CURSOR_W-1:0] wrap_column,
    input  logic                          out_ready,
    output logic                          out_valid,
    output sftg_pkg::coord_t              start_x,
    output sftg_pkg::coord_t              start_y,
    output sftg_pkg::coord_t              end_x,
    output sftg_pkg::coord_t              end_y,
    output logic                          last_segment
);

    sftg_pkg::cursor_t    row_reg, row_next;
    sftg_pkg::cursor_t    col_reg, col_next;
    sftg_pkg::cursor_t    wrap_reg, wrap_next;
    sftg_pkg::cursor_t    draw_row_reg, draw_row_next;
    sftg_pkg::cursor_t    draw_col_reg, draw_col_next;
    sftg_pkg::glyph_idx_t glyph_reg, glyph_next;
    sftg_pkg::seg_cnt_t   count_reg, count_next;
    sftg_pkg::seg_idx_t   seg_idx_reg, seg_idx_next;
    logic                 out_valid_reg, out_valid_next;
    sftg_pkg::coord_t     sx_reg, sx_next;
    sftg_pkg::coord_t     sy_reg, sy_next;
    sftg_pkg::coord_t     ex_reg, ex_next;
    sftg_pkg::coord_t     ey_reg, ey_next;
    logic                 last_reg, last_next;

    logic                 is_space;
    logic                 is_newline;
    logic                 has_glyph;
    logic                 wrap_hit;
    logic                 last_seg;
    sftg_pkg::cursor_t    row_base;
    sftg_pkg::cursor_t    col_base;
    sftg_pkg::cursor_t    row_draw;
    sftg_pkg::cursor_t    col_draw;
    sftg_pkg::stroke_t    stroke;

    // Cell origin is cursor*10+4; the glyph offset is added for x and
    // subtracted for y since the screen y axis points down.
    function automatic sftg_pkg::coord_t coord_calc(
        input sftg_pkg::cursor_t   c,
        input logic signed [3:0]   d,
        input logic                negate
    );
        logic [sftg_pkg::BASE_W-1:0]       b;
        logic signed [sftg_pkg::SUM_W-1:0] s;
        logic signed [sftg_pkg::SUM_W-1:0] dx;
        b  = (sftg_pkg::BASE_W'(c) << 3) + (sftg_pkg::BASE_W'(c) << 1)
           + sftg_pkg::BASE_W'(4);
        dx = sftg_pkg::SUM_W'(d);
        if (negate)
        begin
            s = signed'(sftg_pkg::SUM_W'(b)) - dx;
        end
        else
        begin
            s = signed'(sftg_pkg::SUM_W'(b)) + dx;
        end
        if (s[sftg_pkg::SUM_W-1])
        begin
            return '0;
        end
        return s[sftg_pkg::COORD_BITS-1:0];
    endfunction

    always_comb
    begin
        is_space   = (char_code == sftg_pkg::CODE_SPACE);
        is_newline = (char_code == sftg_pkg::CODE_NEWLINE);
        has_glyph  = (char_code >= sftg_pkg::FIRST_GLYPH)
                  && (char_code <= sftg_pkg::LAST_GLYPH);
        row_base   = start_of_text ? '0 : row_reg;
        col_base   = start_of_text ? '0 : col_reg;
        wrap_hit   = !start_of_text && (col_reg > wrap_reg);
        row_draw   = wrap_hit ? sftg_pkg::sat_inc(row_base) : row_base;
        col_draw   = wrap_hit ? '0 : col_base;
        stroke     = sftg_pkg::GLYPH_ROM[glyph_reg][seg_idx_reg];
        last_seg   = (sftg_pkg::CNT_W'(seg_idx_reg) == count_reg - sftg_pkg::CNT_W'(1));
    end

    always_comb
    begin
        status.has_glyph = has_glyph;
        status.last_seg  = last_seg;
        status.out_free  = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        wrap_next      = wrap_column_we ? wrap_column : wrap_reg;
        draw_row_next  = draw_row_reg;
        draw_col_next  = draw_col_reg;
        glyph_next     = glyph_reg;
        count_next     = count_reg;
        seg_idx_next   = seg_idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        last_next      = last_reg;

        if (cmd.accept)
        begin
            priority if (is_space)
            begin
                row_next = row_base;
                col_next = sftg_pkg::sat_inc(col_base);
            end
            else if (is_newline)
            begin
                row_next = sftg_pkg::sat_inc(row_base);
                col_next = '0;
            end
            else
            begin
                row_next = row_draw;
                col_next = sftg_pkg::sat_inc(col_draw);
            end
            draw_row_next = row_draw;
            draw_col_next = col_draw;
            glyph_next    = sftg_pkg::GLYPH_W'(char_code - sftg_pkg::FIRST_GLYPH);
            count_next    = sftg_pkg::SEG_COUNT[sftg_pkg::GLYPH_W'(char_code
                            - sftg_pkg::FIRST_GLYPH)];
            seg_idx_next  = '0;
        end

        if (cmd.load_seg)
        begin
            out_valid_next = 1'b1;
            sx_next        = coord_calc(draw_col_reg, signed'(stroke[15:12]), 1'b0);
            sy_next        = coord_calc(draw_row_reg, signed'(stroke[11:8]), 1'b1);
            ex_next        = coord_calc(draw_col_reg, signed'(stroke[7:4]), 1'b0);
            ey_next        = coord_calc(draw_row_reg, signed'(stroke[3:0]), 1'b1);
            last_next      = last_seg;
            seg_idx_next   = seg_idx_reg + sftg_pkg::seg_idx_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            col_reg       <= '0;
            wrap_reg      <= sftg_pkg::WRAP_RESET;
            seg_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            wrap_reg      <= wrap_next;
            seg_idx_reg   <= seg_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        draw_row_reg <= draw_row_next;
        draw_col_reg <= draw_col_next;
        glyph_reg    <= glyph_next;
        count_reg    <= count_next;
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        last_reg     <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign start_x      = sx_reg;
    assign start_y      = sy_reg;
    assign end_x        = ex_reg;
    assign end_y        = ey_reg;
    assign last_segment = last_reg;

endmodule

>>> hdl/stroke_font_text_generator_unit.sv
// ----------------------------------------------------------------------------
// Stroke font text generator
// Each character is accepted in ST_IDLE; a drawable glyph then enters ST_EMIT,
// which reads one stroke per cycle from the ROM into the single output register
// while that register is free, so one segment leaves per cycle unless the
// receiver stalls. Space, newline and undrawn codes never leave ST_IDLE.
// Reset clears both cursors, sets the wrap column to 80 and empties the output.
// ----------------------------------------------------------------------------
module stroke_font_text_generator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    sftg_char_if.sink                     char_in,
    sftg_seg_if.source                    seg_out,
    input  logic                          wrap_column_we,
    input  logic [sftg_pkg::CURSOR_W-1:0] wrap_column
);

    sftg_pkg::sftg_cmd_t    cmd;
    sftg_pkg::sftg_status_t status;

    sftg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (char_in.valid),
        .in_ready (char_in.ready),
        .status   (status),
        .cmd      (cmd)
    );

    sftg_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .char_code      (char_in.char_code),
        .start_of_text  (char_in.start_of_text),
        .wrap_column_we (wrap_column_we),
        .wrap_column    (wrap_column),
        .out_ready      (seg_out.ready),
        .out_valid      (seg_out.valid),
        .start_x        (seg_out.start_x),
        .start_y        (seg_out.start_y),
        .end_x          (seg_out.end_x),
        .end_y          (seg_out.end_y),
        .last_segment   (seg_out.last_segment)
    );

endmodule

>>> hdl/sftg_checker.sv
// ----------------------------------------------------------------------------
// Stroke font text generator checker
// Port-level assertions on the generator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "stroke_font_text_generator_unit_assert.svh"

module sftg_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input sftg_pkg::coord_t start_x,
    input sftg_pkg::coord_t start_y,
    input sftg_pkg::coord_t end_x,
    input sftg_pkg::coord_t end_y,
    input logic             last_segment
);

    logic [4*sftg_pkg::COORD_BITS:0] seg_payload;
    logic                            cell_ok;

    assign seg_payload = {start_x, start_y, end_x, end_y, last_segment};

    // Both end points of a stroke lie within eight quarter units of each other.
    assign cell_ok = ({1'b0, end_x} <= {1'b0, start_x} + 15'd8)
                  && ({1'b0, start_x} <= {1'b0, end_x} + 15'd8)
                  && ({1'b0, end_y} <= {1'b0, start_y} + 15'd8)
                  && ({1'b0, start_y} <= {1'b0, end_y} + 15'd8);

    // A stalled segment keeps its payload until the transaction completes.
    `SFTG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(seg_payload), "stalled segment changed")

    // A new character may only be taken once the last stroke of a glyph has reached the output.
    `SFTG_ASSERT_SAME(a_ready_last, clk, rst_n, in_ready && out_valid, last_segment, "ready mid glyph")

    // Every stroke spans no more than eight quarter units in x and in y.
    `SFTG_ASSERT_SAME(a_cell_span, clk, rst_n, out_valid, cell_ok, "segment leaves its cell")

    // The output stage is empty while reset is held.
    `SFTG_ASSERT_RAW(a_reset_empty, clk, !rst_n, !out_valid, "segment valid during reset")

endmodule

bind stroke_font_text_generator_unit sftg_checker u_sftg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (char_in.ready),
    .out_valid    (seg_out.valid),
    .out_ready    (seg_out.ready),
    .start_x      (seg_out.start_x),
    .start_y      (seg_out.start_y),
    .end_x        (seg_out.end_x),
    .end_y        (seg_out.end_y),
    .last_segment (seg_out.last_segment)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stroke font text generator testbench
// Sends text characters through the character channel and checks every line
// segment against a cursor and glyph model kept in a small scoreboard. Covers
// all glyphs, undrawn codes, spaces, newlines, text starts, line wrapping at
// several wrap columns and random stalls on both channels.
// ----------------------------------------------------------------------------

typedef struct packed {
    sftg_pkg::coord_t start_x;
    sftg_pkg::coord_t start_y;
    sftg_pkg::coord_t end_x;
    sftg_pkg::coord_t end_y;
    logic             last_segment;
} segment_t;

class glyph_scoreboard;
    // Strokes as signed nibbles x0, y0, x1, y1 in quarter units, y upward.
    localparam logic [0:44][0:4][15:0] STROKES = {
        16'h0C0C, 16'h0C0C, 16'h0C0C, 16'h0C0C, 16'h0000,   // .
        16'h44CC, 16'h0000, 16'h0000, 16'h0000, 16'h0000,   // /
        16'hC444, 16'hC4CC, 16'hCC4C, 16'h444C, 16'h0000,   // 0
        16'h040C, 16'h0000, 16'h0000, 16'h0000, 16'h0000,   // 1
        16'hC004, 16'h0440, 16'h40CC, 16'hCC4C, 16'h0000,   // 2
        16'hC444, 16'hC040, 16'hCC4C, 16'h444C, 16'h0000,   // 3
        16'hC4C0, 16'hC040, 16'h444C, 16'h0000, 16'h0000,   // 4
        16'h44C4, 16'hC4C0, 16'hC040, 16'h404C, 16'h4CCC,   // 5
        16'h44C4, 16'hC4CC, 16'hCC4C, 16'h4C40, 16'h40C0,   // 6
        16'hC444, 16'h44CC, 16'h0000, 16'h0000, 16'h0000,   // 7
        16'hCCC4, 16'hC444, 16'h444C, 16'h4CCC, 16'hC040,   // 8
        16'hC0C4, 16'hC444, 16'h444C, 16'h4CCC, 16'hC040,   // 9
        16'h0301, 16'h0D01, 16'h0000, 16'h0000, 16'h0000,   // :
        16'h0301, 16'h0DF1, 16'h0000, 16'h0000, 16'h0000,   // ;
        16'h44C0, 16'hC04C, 16'h0000, 16'h0000, 16'h0000,   // <
        16'hC242, 16'hCE4E, 16'h0000, 16'h0000, 16'h0000,   // =
        16'hC440, 16'h40CC, 16'h0000, 16'h0000, 16'h0000,   // >
        16'hC444, 16'h4440, 16'h4000, 16'h000F, 16'h0D0C,   // ?
        16'hCC44, 16'h0000, 16'h0000, 16'h0000, 16'h0000,   // @
        16'hCC04, 16'h044C, 16'hE020, 16'h0000, 16'h0000,   // A
        16'hC4CC, 16'hC442, 16'h42C0, 16'hC04E, 16'h4ECC,   // B
        16'hC444, 16'hC4CC, 16'hCC4C, 16'h0000, 16'h0000,   // C
        16'hC4CC, 16'hC440, 16'h40CC, 16'h0000, 16'h0000,   // D
        16'hC444, 16'hC4CC, 16'hCC4C, 16'hC040, 16'h0000,   // E
        16'hC444, 16'hC4CC, 16'hC040, 16'h0000, 16'h0000,   // F
        16'hC444, 16'hC4CC, 16'hCC4C, 16'h4C40, 16'h4000,   // G
        16'hC4CC, 16'h444C, 16'hC040, 16'h0000, 16'h0000,   // H
        16'hC444, 16'h040C, 16'hCC4C, 16'h0000, 16'h0000,   // I
        16'hC444, 16'h040C, 16'hCC0C, 16'hCCC0, 16'h0000,   // J
        16'hC4CC, 16'hC044, 16'hC04C, 16'h0000, 16'h0000,   // K
        16'hC4CC, 16'hCC4C, 16'h0000, 16'h0000, 16'h0000,   // L
        16'hC4CC, 16'hC400, 16'h0044, 16'h444C, 16'h0000,   // M
        16'hC4CC, 16'hC44C, 16'h444C, 16'h0000, 16'h0000,   // N
        16'hC444, 16'hC4CC, 16'hCC4C, 16'h444C, 16'h0000,   // O
        16'hC4CC, 16'hC442, 16'h42C0, 16'h0000, 16'h0000,   // P
        16'hC444, 16'hC4CC, 16'hCC4C, 16'h444C, 16'h004C,   // Q
        16'hC4CC, 16'hC442, 16'h42C0, 16'hC04C, 16'h0000,   // R
        16'h44C2, 16'hC24E, 16'h4ECC, 16'h0000, 16'h0000,   // S
        16'hC444, 16'h040C, 16'h0000, 16'h0000, 16'h0000,   // T
        16'hC4CC, 16'hCC4C, 16'h444C, 16'h0000, 16'h0000,   // U
        16'hC40C, 16'h0C44, 16'h0000, 16'h0000, 16'h0000,   // V
        16'hC4CC, 16'hCC00, 16'h004C, 16'h4C44, 16'h0000,   // W
        16'hC44C, 16'hCC44, 16'h0000, 16'h0000, 16'h0000,   // X
        16'hC400, 16'h4400, 16'h000C, 16'h0000, 16'h0000,   // Y
        16'hC444, 16'h44CC, 16'hCC4C, 16'h0000, 16'h0000    // Z
    };

    localparam logic [0:44][2:0] STROKE_COUNT = {
        3'd4, 3'd1, 3'd4, 3'd1, 3'd4, 3'd4, 3'd3, 3'd5, 3'd5, 3'd2,
        3'd5, 3'd5, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd5, 3'd1, 3'd3,
        3'd5, 3'd3, 3'd3, 3'd4, 3'd3, 3'd5, 3'd3, 3'd3, 3'd4, 3'd3,
        3'd2, 3'd4, 3'd3, 3'd4, 3'd3, 3'd5, 3'd4, 3'd3, 3'd2, 3'd3,
        3'd2, 3'd4, 3'd2, 3'd3, 3'd3
    };

    localparam int REPORT_LIMIT = 10;

    sftg_pkg::cursor_t row;
    sftg_pkg::cursor_t col;
    sftg_pkg::cursor_t wrap_limit;
    segment_t          pending[$];
    int                mismatches;
    int                checked;

    function new();
        row        = '0;
        col        = '0;
        wrap_limit = 10'd80;
        mismatches = 0;
        checked    = 0;
    endfunction

    static function sftg_pkg::cursor_t bump(sftg_pkg::cursor_t v);
        return (v == 10'd1023) ? v : v + 10'd1;
    endfunction

    static function int nibble(logic [3:0] v);
        return int'($signed(v));
    endfunction

    static function sftg_pkg::coord_t place(sftg_pkg::cursor_t base, int delta);
        int v;
        v = int'(base) * 10 + 4 + delta;
        if (v < 0)
            v = 0;
        return sftg_pkg::coord_t'(v);
    endfunction

    // Advances the cursors for one accepted character and queues its segments.
    function void note_char(logic [7:0] code, logic sot);
        int          g;
        int          n;
        logic [15:0] s;
        segment_t    seg;
        if (sot)
        begin
            row = '0;
            col = '0;
        end
        if (code == sftg_pkg::CODE_SPACE)
        begin
            col = bump(col);
            return;
        end
        if (code == sftg_pkg::CODE_NEWLINE)
        begin
            row = bump(row);
            col = '0;
            return;
        end
        if (!sot && col > wrap_limit)
        begin
            row = bump(row);
            col = '0;
        end
        g = int'(code) - int'(sftg_pkg::FIRST_GLYPH);
        if (g >= 0 && g < sftg_pkg::GLYPH_COUNT)
        begin
            n = int'(STROKE_COUNT[g]);
            for (int k = 0; k < n; k++)
            begin
                s                = STROKES[g][k];
                seg.start_x      = place(col, nibble(s[15:12]));
                seg.start_y      = place(row, -nibble(s[11:8]));
                seg.end_x        = place(col, nibble(s[7:4]));
                seg.end_y        = place(row, -nibble(s[3:0]));
                seg.last_segment = (k == n - 1);
                pending.push_back(seg);
            end
        end
        col = bump(col);
    endfunction

    function void check_segment(segment_t got);
        segment_t want;
        checked++;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("ERROR: unexpected segment (%0d,%0d)-(%0d,%0d) last=%0b",
                         got.start_x, got.start_y, got.end_x, got.end_y, got.last_segment);
            return;
        end
        want = pending.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("ERROR: segment %0d expected (%0d,%0d)-(%0d,%0d) last=%0b,",
                         checked, want.start_x, want.start_y, want.end_x, want.end_y,
                         want.last_segment,
                         " got (%0d,%0d)-(%0d,%0d) last=%0b",
                         got.start_x, got.start_y, got.end_x, got.end_y,
                         got.last_segment);
        end
    endfunction
endclass

module testbench;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;

    logic          clk;
    logic          rst_n;
    logic          wrap_column_we;
    logic [9:0]    wrap_column;

    sftg_char_if   char_bus ();
    sftg_seg_if    seg_bus ();

    glyph_scoreboard board;

    int send_gap_pct   = 0;
    int accept_gap_pct = 0;
    int chars_sent     = 0;
    int wrap_writes    = 0;
    int cycle_count    = 0;

    stroke_font_text_generator_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_in        (char_bus),
        .seg_out        (seg_bus),
        .wrap_column_we (wrap_column_we),
        .wrap_column    (wrap_column)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d segments outstanding",
                     cycle_count, board.pending.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Segment monitor; the receiver stall for the next cycle is drawn here.
    always @(posedge clk)
    begin
        if (rst_n && seg_bus.valid && seg_bus.ready)
            board.check_segment('{start_x: seg_bus.start_x, start_y: seg_bus.start_y,
                                   end_x: seg_bus.end_x, end_y: seg_bus.end_y,
                                   last_segment: seg_bus.last_segment});
        seg_bus.ready <= ($urandom_range(0, 99) >= accept_gap_pct);
    end

    task automatic send_char(input logic [7:0] code, input logic sot);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
        end
        char_bus.valid         <= 1'b1;
        char_bus.char_code     <= code;
        char_bus.start_of_text <= sot;
        @(posedge clk);
        while (!char_bus.ready)
            @(posedge clk);
        board.note_char(code, sot);
        chars_sent++;
    endtask

    // Undrawn codes leave no segment behind, so a few cycles pass after the
    // last expected segment before the block counts as idle.
    task automatic settle();
        char_bus.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_wrap(input logic [9:0] v);
        wrap_column_we <= 1'b1;
        wrap_column    <= v;
        @(posedge clk);
        board.wrap_limit = v;
        wrap_column_we <= 1'b0;
        wrap_writes++;
    endtask

    task automatic directed_text();
        send_char(".", 1'b1);
        send_char("/", 1'b0);
        send_char("0", 1'b0);
        send_char("?", 1'b0);
        send_char(";", 1'b0);
        send_char(sftg_pkg::CODE_SPACE, 1'b0);
        send_char("=", 1'b0);
        send_char("!", 1'b0);
        send_char("A", 1'b0);
        send_char(sftg_pkg::CODE_NEWLINE, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_char("Z", 1'b0);
        send_char("[", 1'b0);
        send_char(8'h80, 1'b0);
        send_char(sftg_pkg::CODE_SPACE, 1'b1);
        send_char("@", 1'b0);
        send_char(sftg_pkg::CODE_NEWLINE, 1'b1);
        send_char("B", 1'b0);
        send_char(8'h7F, 1'b1);
        send_char("5", 1'b0);
        send_char("W", 1'b0);
        send_char("Q", 1'b0);
        send_char(":", 1'b0);
        send_char("8", 1'b0);
    endtask

    // Mostly drawable text with spaces and newlines, some undrawn codes and
    // an occasional start of a new text.
    task automatic random_text(input int count);
        logic [7:0] code;
        int         pick;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                code = sftg_pkg::FIRST_GLYPH
                     + 8'($urandom_range(0, sftg_pkg::GLYPH_COUNT - 1));
            else if (pick < 70)
                code = sftg_pkg::CODE_SPACE;
            else if (pick < 77)
                code = sftg_pkg::CODE_NEWLINE;
            else if (pick < 90)
                code = 8'($urandom_range(0, 255));
            else
                code = 8'($urandom_range(int'(sftg_pkg::LAST_GLYPH) + 1, 255));
            send_char(code, $urandom_range(0, 11) == 0);
        end
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        wrap_column_we         <= 1'b0;
        wrap_column            <= '0;
        char_bus.valid         <= 1'b0;
        char_bus.char_code     <= '0;
        char_bus.start_of_text <= 1'b0;
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_wrap(10'd2);
        directed_text();
        settle();

        send_gap_pct   = 19;
        accept_gap_pct = 65;
        write_wrap(10'd0);
        random_text(50);
        settle();

        send_gap_pct   = 65;
        accept_gap_pct = 19;
        write_wrap(10'd1023);
        random_text(50);
        settle();

        send_gap_pct   = 0;
        accept_gap_pct = 0;
        write_wrap(10'($urandom_range(1, 12)));
        random_text(50);
        settle();

        // Draw every glyph on one line of a new text.
        write_wrap(10'd1023);
        send_char("A", 1'b1);
        for (int g = 0; g < sftg_pkg::GLYPH_COUNT; g++)
            send_char(sftg_pkg::FIRST_GLYPH + 8'(g), 1'b0);
        settle();

        // A lower wrap column forces a wrap on the next printable character, and an
        // undrawn code then only advances the column before a new text begins.
        write_wrap(10'd1);
        send_char("W", 1'b0);
        send_char(8'hC3, 1'b0);
        send_char("H", 1'b1);
        settle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d characters under %0d wrap column writes, checked %0d segments.",
                 chars_sent, wrap_writes, board.checked);
        $display("Run covered all glyphs, undrawn codes, text starts and line wraps.");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> stroke_font_text_generator_unit.f
+incdir+hdl
hdl/sftg_pkg.sv
hdl/sftg_char_if.sv
hdl/sftg_seg_if.sv
hdl/sftg_ctrl.sv
hdl/sftg_datapath.sv
hdl/stroke_font_text_generator_unit.sv
hdl/sftg_checker.sv
dv/testbench.sv
